// ===== src/u8u16_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared types, constants and a lookup function for the UTF-8 to UTF-16
// transcoder: byte classes, the validating automaton's transition table and
// the step result bundle.
// ----------------------------------------------------------------------------
package u8u16_pkg;

   localparam int unsigned STATE_W = 4;
   localparam int unsigned CLASS_W = 4;
   localparam int unsigned CP_W    = 21;
   localparam int unsigned UNIT_W  = 16;
   localparam int unsigned N_STATES  = 9;
   localparam int unsigned N_CLASSES = 12;

   localparam logic [STATE_W-1:0] ST_ACCEPT = 4'd0;
   localparam logic [STATE_W-1:0] ST_REJECT = 4'd1;
   localparam logic [STATE_W-1:0] ST_LAST   = 4'd8;

   localparam logic [UNIT_W-1:0] REPL_UNIT     = 16'hFFFD;
   localparam logic [CP_W-1:0]   CP_LIMIT      = 21'h10FFFF;
   localparam logic [CP_W-1:0]   SURR_LO       = 21'h00D800;
   localparam logic [CP_W-1:0]   SURR_HI       = 21'h00DFFF;
   localparam logic [CP_W-1:0]   BMP_MAX       = 21'h00FFFF;
   localparam logic [UNIT_W-1:0] LOW_SURR_BASE = 16'hDC00;
   localparam logic [UNIT_W-1:0] HIGH_OFFSET   = 16'hD7C0;
   localparam logic [7:0]        CONT_MASK     = 8'h3F;
   localparam logic [7:0]        LEAD_MASK     = 8'hFF;

   localparam logic [STATE_W-1:0] NEXT_STATE_TABLE [N_STATES][N_CLASSES] = '{
      '{4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd7, 4'd1, 4'd1, 4'd1, 4'd4, 4'd6},
      '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd0, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd0, 4'd1, 4'd0, 4'd1, 4'd1},
      '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd2, 4'd1, 4'd1},
      '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1},
      '{4'd1, 4'd2, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd2, 4'd1, 4'd1},
      '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
      '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd1, 4'd3, 4'd1, 4'd1},
      '{4'd1, 4'd3, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1}
   };

   typedef struct packed {
      logic [STATE_W-1:0] next_state;
      logic [CP_W-1:0]    next_partial;
      logic               emit;
      logic               pair;
      logic [UNIT_W-1:0]  unit0;
      logic               last0;
      logic               repl0;
      logic [UNIT_W-1:0]  unit1;
   } step_type;

   function automatic logic [CLASS_W-1:0] byte_class(input logic [7:0] b);
      logic [CLASS_W-1:0] cls;
      priority if (b < 8'h80) cls = 4'd0;
      else if (b < 8'h90)     cls = 4'd1;
      else if (b < 8'hA0)     cls = 4'd9;
      else if (b < 8'hC0)     cls = 4'd7;
      else if (b < 8'hC2)     cls = 4'd8;
      else if (b < 8'hE0)     cls = 4'd2;
      else if (b == 8'hE0)    cls = 4'd10;
      else if (b == 8'hED)    cls = 4'd4;
      else if (b < 8'hF0)     cls = 4'd3;
      else if (b == 8'hF0)    cls = 4'd11;
      else if (b < 8'hF4)     cls = 4'd6;
      else if (b == 8'hF4)    cls = 4'd5;
      else                    cls = 4'd8;
      return cls;
   endfunction

endpackage

// ===== src/u8u16_step.sv =====
// ----------------------------------------------------------------------------
// u8u16_step
// One automaton step: classifies a byte, moves the state, folds the payload
// bits into the partial code point and forms the UTF-16 units to send.
// ----------------------------------------------------------------------------
module u8u16_step
   import u8u16_pkg::*;
(
   input  logic [STATE_W-1:0] cur_state,
   input  logic [CP_W-1:0]    cur_partial,
   input  logic [7:0]         in_byte,
   output step_type           step
);

   logic [CLASS_W-1:0] cls;
   logic [STATE_W-1:0] state_eff;
   logic [STATE_W-1:0] nxt;
   logic [CP_W-1:0]    cp;
   logic [7:0]         lead_bits;
   logic               bad_value;
   logic [UNIT_W-1:0]  high_unit;

   always_comb begin
      cls       = byte_class(in_byte);
      state_eff = (cur_state > ST_LAST) ? ST_REJECT : cur_state;
      lead_bits = LEAD_MASK >> cls;
      if (state_eff != ST_ACCEPT) begin
         cp = {cur_partial[CP_W-7:0], 6'(in_byte & CONT_MASK)};
      end else begin
         cp = {{(CP_W-8){1'b0}}, lead_bits & in_byte};
      end
      nxt       = NEXT_STATE_TABLE[state_eff][cls];
      bad_value = (cp > CP_LIMIT) || ((cp >= SURR_LO) && (cp <= SURR_HI));
      high_unit = 16'(cp >> 10) + HIGH_OFFSET;

      step.next_state   = ST_ACCEPT;
      step.next_partial = '0;
      step.emit         = 1'b1;
      step.pair         = 1'b0;
      step.unit0        = REPL_UNIT;
      step.last0        = 1'b1;
      step.repl0        = 1'b1;
      step.unit1        = {6'b0, cp[9:0]} | LOW_SURR_BASE;

      if (nxt == ST_ACCEPT) begin
         if (bad_value) begin
            step.unit0 = REPL_UNIT;
         end else if (cp > BMP_MAX) begin
            step.pair  = 1'b1;
            step.unit0 = high_unit;
            step.last0 = 1'b0;
            step.repl0 = 1'b0;
         end else begin
            step.unit0 = cp[UNIT_W-1:0];
            step.repl0 = 1'b0;
         end
      end else if (nxt != ST_REJECT) begin
         step.emit         = 1'b0;
         step.next_state   = nxt;
         step.next_partial = cp;
      end
   end

endmodule

// ===== src/utf8_to_utf16_transcoder_core.sv =====
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder_core
// Validating UTF-8 to UTF-16 transcoder, one byte per transfer.
// ----------------------------------------------------------------------------
// The block takes one UTF-8 byte per cycle when not stalled and gives zero,
// one or two UTF-16 units per byte: nothing while a sequence is open, one
// unit for a completed BMP character or for U+FFFD on malformed input
// (replaced set), and a high then low surrogate for characters above U+FFFF.
// last_unit marks the final unit a byte produced. A byte is registered,
// decoded combinationally and the units land in a result register, so bytes
// flow at one per cycle while the result side takes units; a surrogate pair
// holds the next byte until its low surrogate is taken. One byte can wait
// in the input register while a result is stalled.
module utf8_to_utf16_transcoder_core
   import u8u16_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [7:0]        req_in_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [UNIT_W-1:0] rsp_code_unit,
   output logic              rsp_last_unit,
   output logic              rsp_replaced
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff, in_byte_in;
   logic [STATE_W-1:0] state_ff, state_in;
   logic [CP_W-1:0]    partial_ff, partial_in;
   logic               out_valid_ff, out_valid_in;
   logic               pair_ff, pair_in;
   logic [UNIT_W-1:0]  head_unit_ff, head_unit_in;
   logic               head_last_ff, head_last_in;
   logic               head_repl_ff, head_repl_in;
   logic [UNIT_W-1:0]  tail_unit_ff, tail_unit_in;

   step_type step;
   logic     req_take;
   logic     pop;
   logic     slot_free;
   logic     advance;

   u8u16_step u_step (
      .cur_state   (state_ff),
      .cur_partial (partial_ff),
      .in_byte     (in_byte_ff),
      .step        (step)
   );

   assign pop       = out_valid_ff && !rsp_stall;
   assign slot_free = !out_valid_ff || (pop && !pair_ff);
   assign advance   = in_valid_ff && slot_free;
   assign req_stall = in_valid_ff && !slot_free;
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      state_in     = state_ff;
      partial_in   = partial_ff;
      out_valid_in = out_valid_ff;
      pair_in      = pair_ff;
      head_unit_in = head_unit_ff;
      head_last_in = head_last_ff;
      head_repl_in = head_repl_ff;
      tail_unit_in = tail_unit_ff;

      // result register drain
      if (pop) begin
         if (pair_ff) begin
            pair_in      = 1'b0;
            head_unit_in = tail_unit_ff;
            head_last_in = 1'b1;
            head_repl_in = 1'b0;
         end else begin
            out_valid_in = 1'b0;
         end
      end

      // decode the registered byte
      if (advance) begin
         state_in   = step.next_state;
         partial_in = step.next_partial;
         if (step.emit) begin
            out_valid_in = 1'b1;
            pair_in      = step.pair;
            head_unit_in = step.unit0;
            head_last_in = step.last0;
            head_repl_in = step.repl0;
            tail_unit_in = step.unit1;
         end
      end

      // input register
      if (req_take) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         state_ff     <= ST_ACCEPT;
         partial_ff   <= '0;
         out_valid_ff <= 1'b0;
         pair_ff      <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         state_ff     <= state_in;
         partial_ff   <= partial_in;
         out_valid_ff <= out_valid_in;
         pair_ff      <= pair_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      head_unit_ff <= head_unit_in;
      head_last_ff <= head_last_in;
      head_repl_ff <= head_repl_in;
      tail_unit_ff <= tail_unit_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_code_unit = head_unit_ff;
   assign rsp_last_unit = head_last_ff;
   assign rsp_replaced  = head_repl_ff;

endmodule
